// ===== sv/rbc_pkg.sv =====
package rbc_pkg;

    // Datapath sizing
    localparam int ACC_WIDTH  = 64;
    localparam int MAX_DIGITS = 64;
    localparam int BASE_W     = 6;
    localparam int CHAR_W     = 8;
    localparam int DIGIT_W    = 9;
    localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
    localparam int IDX_W      = $clog2(MAX_DIGITS);

    // Divider: quotient bits retired per cycle
    localparam int DIV_BITS  = 4;
    localparam int DIV_STEPS = (ACC_WIDTH + DIV_BITS - 1) / DIV_BITS;
    localparam int DIV_PAD_W = DIV_STEPS * DIV_BITS;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration port
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;
    localparam int REG_SEL_BIT = 2;
    localparam logic REG_IN_BASE  = 1'b0;
    localparam logic REG_OUT_BASE = 1'b1;
    localparam logic [BASE_W-1:0] BASE_RESET = 6'd10;
    localparam logic [BASE_W-1:0] BASE_MIN   = 6'd2;
    localparam logic [BASE_W-1:0] BASE_MAX   = 6'd36;

    // Character codes
    localparam logic [CHAR_W-1:0] CODE_DIGIT_LO = 8'd48;
    localparam logic [CHAR_W-1:0] CODE_DIGIT_HI = 8'd58;
    localparam logic [CHAR_W-1:0] CODE_ALPHA_OFS = 8'd55;
    localparam logic [CHAR_W-1:0] CHAR_ZERO      = 8'd48;
    localparam logic [BASE_W-1:0] DEC_DIGITS     = 6'd10;

    // One decoded input item
    typedef struct packed {
        logic signed [DIGIT_W-1:0] digit;
        logic                      last;
    } rbc_item_t;

    // Divider request and response
    typedef struct packed {
        logic                 start;
        logic [ACC_WIDTH-1:0] dividend;
        logic [BASE_W-1:0]    divisor;
    } rbc_div_req_t;

    typedef struct packed {
        logic                 done;
        logic [ACC_WIDTH-1:0] quotient;
        logic [BASE_W-1:0]    remainder;
    } rbc_div_rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD,
        ST_ZERO,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_EMIT_RD,
        ST_EMIT_WR
    } rbc_state_t;

    // Limit a radix register to the supported range
    function automatic logic [BASE_W-1:0] clamp_base(input logic [BASE_W-1:0] b);
        if (b < BASE_MIN)
            return BASE_MIN;
        else if (b > BASE_MAX)
            return BASE_MAX;
        else
            return b;
    endfunction

    // Digit value 0..35 to its character 0-9, A-Z
    function automatic logic [CHAR_W-1:0] digit_glyph(input logic [BASE_W-1:0] d);
        if (d < DEC_DIGITS)
            return CHAR_ZERO + CHAR_W'(d);
        else
            return CODE_ALPHA_OFS + CHAR_W'(d);
    endfunction

endpackage

// ===== sv/rbc_front.sv =====
module rbc_front
    import rbc_pkg::*;
(
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [CHAR_W-1:0] in_code,
    input  logic              in_last,
    input  logic              q_full,
    output logic              q_push,
    output rbc_item_t         q_item
);

    logic signed [DIGIT_W-1:0] digit;

    // Decode the character; codes outside the decimal band take the letter offset
    always_comb
    begin
        if (in_code >= CODE_DIGIT_LO && in_code <= CODE_DIGIT_HI)
            digit = $signed({1'b0, in_code - CODE_DIGIT_LO});
        else
            digit = $signed({1'b0, in_code}) - $signed({1'b0, CODE_ALPHA_OFS});
    end

    // Transfer straight into the queue while it has room
    assign in_ready     = !q_full;
    assign q_push       = in_valid && !q_full;
    assign q_item.digit = digit;
    assign q_item.last  = in_last;

endmodule

// ===== sv/rbc_fifo.sv =====
module rbc_fifo
    import rbc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  rbc_item_t push_item,
    output logic      full,
    input  logic      pop,
    output rbc_item_t pop_item,
    output logic      empty
);

    rbc_item_t           entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;

    assign full     = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_item = entry_reg[rd_ptr_reg];

    // Pointer and occupancy update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_item;
    end

endmodule

// ===== sv/rbc_divider.sv =====
module rbc_divider
    import rbc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  rbc_div_req_t req,
    output rbc_div_rsp_t rsp
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [STEP_W-1:0]    step_reg;
    logic [BASE_W-1:0]    rem_reg;
    logic [BASE_W-1:0]    rem_next;
    logic [DIV_PAD_W-1:0] shift_reg;
    logic [DIV_PAD_W-1:0] shift_next;
    logic [BASE_W-1:0]    divisor_reg;

    // Restoring division, DIV_BITS quotient bits per cycle
    always_comb
    begin
        logic [BASE_W:0] trial;
        rem_next   = rem_reg;
        shift_next = shift_reg;
        for (int i = 0; i < DIV_BITS; i++)
        begin
            trial      = {rem_next, shift_next[DIV_PAD_W-1]};
            shift_next = {shift_next[DIV_PAD_W-2:0], 1'b0};
            if (trial >= {1'b0, divisor_reg})
            begin
                rem_next      = BASE_W'(trial - {1'b0, divisor_reg});
                shift_next[0] = 1'b1;
            end
            else
                rem_next = trial[BASE_W-1:0];
        end
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + 1'b1;
            if (step_reg == STEP_W'(DIV_STEPS - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
            done_reg <= 1'b0;
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg     <= '0;
            shift_reg   <= DIV_PAD_W'(req.dividend);
            divisor_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg   <= rem_next;
            shift_reg <= shift_next;
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = shift_reg[ACC_WIDTH-1:0];
    assign rsp.remainder = rem_reg;

endmodule

// ===== sv/rbc_back.sv =====
module rbc_back
    import rbc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [BASE_W-1:0] in_base,
    input  logic [BASE_W-1:0] out_base,
    input  logic              q_empty,
    input  rbc_item_t         q_item,
    output logic              q_pop,
    output rbc_div_req_t      div_req,
    input  rbc_div_rsp_t      div_rsp,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [CHAR_W-1:0] out_char,
    output logic              out_last
);

    rbc_state_t                state_reg;
    rbc_state_t                state_next;
    logic [ACC_WIDTH-1:0]      acc_reg;
    logic [ACC_WIDTH-1:0]      acc_next;
    logic [ACC_WIDTH-1:0]      prod_reg;
    logic [ACC_WIDTH-1:0]      prod_next;
    logic [ACC_WIDTH-1:0]      val_reg;
    logic [ACC_WIDTH-1:0]      val_next;
    logic signed [DIGIT_W-1:0] digit_reg;
    logic                      last_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic [CNT_W-1:0]          cnt_next;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic [CHAR_W-1:0]         out_char_reg;
    logic [CHAR_W-1:0]         out_char_next;
    logic                      out_last_reg;
    logic                      out_last_next;

    logic [BASE_W-1:0]         stack_mem [MAX_DIGITS];
    logic [BASE_W-1:0]         rd_data_reg;
    logic                      wr_en;
    logic [IDX_W-1:0]          wr_addr;
    logic [IDX_W-1:0]          rd_addr;

    logic [ACC_WIDTH+BASE_W-1:0] mul_full;
    logic signed [ACC_WIDTH-1:0] digit_ext;
    logic [ACC_WIDTH-1:0]        sum;
    logic                        slot_free;
    logic [CNT_W-1:0]            cnt_inc;

    // Multiply-add datapath
    assign mul_full  = {{BASE_W{1'b0}}, acc_reg} * {{ACC_WIDTH{1'b0}}, in_base};
    assign prod_next = mul_full[ACC_WIDTH-1:0];
    assign digit_ext = ACC_WIDTH'(digit_reg);
    assign sum       = prod_reg + $unsigned(digit_ext);

    assign slot_free = !out_valid_reg || out_ready;
    assign cnt_inc   = cnt_reg + 1'b1;
    assign wr_addr   = cnt_reg[IDX_W-1:0];
    assign rd_addr   = IDX_W'(cnt_reg - 1'b1);

    // Sequencer
    always_comb
    begin
        state_next       = state_reg;
        acc_next         = acc_reg;
        val_next         = val_reg;
        cnt_next         = cnt_reg;
        q_pop            = 1'b0;
        wr_en            = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = val_reg;
        div_req.divisor  = out_base;
        out_valid_next   = out_valid_reg && !out_ready;
        out_char_next    = out_char_reg;
        out_last_next    = out_last_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    state_next = ST_ADD;
                end
            end

            ST_ADD:
            begin
                if (!last_reg)
                begin
                    acc_next   = sum;
                    state_next = ST_IDLE;
                end
                else
                begin
                    acc_next = '0;
                    val_next = sum;
                    cnt_next = '0;
                    if (sum == '0)
                        state_next = ST_ZERO;
                    else
                        state_next = ST_DIV_GO;
                end
            end

            ST_ZERO:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = CHAR_ZERO;
                    out_last_next  = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            ST_DIV_GO:
            begin
                div_req.start = 1'b1;
                state_next    = ST_DIV_WAIT;
            end

            ST_DIV_WAIT:
            begin
                if (div_rsp.done)
                begin
                    wr_en    = 1'b1;
                    cnt_next = cnt_inc;
                    val_next = div_rsp.quotient;
                    if (div_rsp.quotient == '0 || cnt_inc == CNT_W'(MAX_DIGITS))
                        state_next = ST_EMIT_RD;
                    else
                        state_next = ST_DIV_GO;
                end
            end

            ST_EMIT_RD:
            begin
                state_next = ST_EMIT_WR;
            end

            ST_EMIT_WR:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = digit_glyph(rd_data_reg);
                    out_last_next  = (cnt_reg == CNT_W'(1));
                    cnt_next       = cnt_reg - 1'b1;
                    state_next     = (cnt_reg == CNT_W'(1)) ? ST_IDLE : ST_EMIT_RD;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            acc_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            acc_reg       <= acc_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        prod_reg     <= prod_next;
        val_reg      <= val_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
        if (q_pop)
        begin
            digit_reg <= q_item.digit;
            last_reg  <= q_item.last;
        end
    end

    // Digit stack: one write port, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
            stack_mem[wr_addr] <= div_rsp.remainder;
        rd_data_reg <= stack_mem[rd_addr];
    end

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign out_last  = out_last_reg;

endmodule

// ===== sv/radix_base_converter_top.sv =====
// Digit characters: each is popped from the queue, then multiplied and added
// into the accumulator; a 2-entry queue lets the input side run ahead while a
// conversion is emitted. Last character: its sum goes to the iterative divider
// (4 quotient bits per cycle), which yields one output digit per division onto
// a stack; the stack is then read back and emitted. A zero value emits one digit.
// Reset (rst_n, asynchronous, active low) clears the accumulator, the
// sequencer, the queue and sets both radix registers to 10.
module radix_base_converter_top
    import rbc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    // Configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    // Input stream
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [7:0]         s_axis_tdata,   // [7:0] digit_char
    input  logic               s_axis_tlast,
    // Output stream
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [7:0]         m_axis_tdata,   // [7:0] out_char
    output logic               m_axis_tlast
);

    logic [BASE_W-1:0] in_base_reg;
    logic [BASE_W-1:0] out_base_reg;
    logic              cfg_write;
    logic              q_push;
    logic              q_pop;
    logic              q_full;
    logic              q_empty;
    rbc_item_t         push_item;
    rbc_item_t         pop_item;
    rbc_div_req_t      div_req;
    rbc_div_rsp_t      div_rsp;

    // Register file; byte offset bits of paddr are ignored
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_base_reg  <= BASE_RESET;
            out_base_reg <= BASE_RESET;
        end
        else if (cfg_write)
        begin
            case (paddr[REG_SEL_BIT])
                REG_IN_BASE:  in_base_reg  <= pwdata[BASE_W-1:0];
                REG_OUT_BASE: out_base_reg <= pwdata[BASE_W-1:0];
                default:      in_base_reg  <= in_base_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[REG_SEL_BIT])
            REG_IN_BASE:  prdata = PDATA_W'(in_base_reg);
            REG_OUT_BASE: prdata = PDATA_W'(out_base_reg);
            default:      prdata = '0;
        endcase
    end

    rbc_front u_front (
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_code  (s_axis_tdata),
        .in_last  (s_axis_tlast),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (push_item)
    );

    rbc_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .pop_item  (pop_item),
        .empty     (q_empty)
    );

    rbc_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    rbc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_base   (clamp_base(in_base_reg)),
        .out_base  (clamp_base(out_base_reg)),
        .q_empty   (q_empty),
        .q_item    (pop_item),
        .q_pop     (q_pop),
        .div_req   (div_req),
        .div_rsp   (div_rsp),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_char  (m_axis_tdata),
        .out_last  (m_axis_tlast)
    );

endmodule

// ===== sv/rbc_checker.sv =====
module rbc_checker
    import rbc_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               psel,
    input logic               penable,
    input logic               pwrite,
    input logic [PADDR_W-1:0] paddr,
    input logic [PDATA_W-1:0] pwdata,
    input logic [PDATA_W-1:0] prdata,
    input logic               pready,
    input logic               m_axis_tvalid,
    input logic               m_axis_tready,
    input logic [7:0]         m_axis_tdata,
    input logic               m_axis_tlast
);

    // A stalled output transfer holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output transfer changed while stalled");

    // Every emitted character is 0-9 or A-Z
    a_glyph: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |->
            (m_axis_tdata >= 8'd48 && m_axis_tdata <= 8'd57) ||
            (m_axis_tdata >= 8'd65 && m_axis_tdata <= 8'd90))
        else $error("output character outside 0-9, A-Z");

    // A radix register reads back what was last written to it
    a_readback: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && pready) ##1 (paddr[REG_SEL_BIT] ==
            $past(paddr[REG_SEL_BIT])) |->
            prdata == PDATA_W'($past(pwdata[BASE_W-1:0])))
        else $error("register readback mismatch");

    // Configuration port never inserts wait states
    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        psel |-> pready)
        else $error("pready low during access");

endmodule

bind radix_base_converter_top rbc_checker u_checker (.*);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import rbc_pkg::*;

    // Register addresses on the configuration port
    localparam logic [PADDR_W-1:0] ADDR_IN_BASE  = 3'd0;
    localparam logic [PADDR_W-1:0] ADDR_OUT_BASE = 3'd4;

    // Longest run of cycles without any transfer before giving up
    localparam int QUIET_LIMIT = 6000;
    localparam int HOLD_CYCLES = 400;
    localparam int ITEM_TARGET = 320;

    typedef struct {
        logic [7:0] ch;
        logic       last;
    } char_item_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [7:0]         s_axis_tdata = '0;   // [7:0] digit_char
    logic               s_axis_tlast = 1'b0;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [7:0]         m_axis_tdata;        // [7:0] out_char
    logic               m_axis_tlast;

    radix_base_converter_top dut (.*);

    // Shadow of the block's state
    logic [63:0] acc_q;
    logic [5:0]  in_base_q;
    logic [5:0]  out_base_q;

    char_item_t  send_q[$];
    char_item_t  want_q[$];

    int  n_queued = 0;
    int  n_numbers = 0;
    int  n_in = 0;
    int  n_out = 0;
    int  n_err = 0;
    int  n_cfg = 0;
    int  quiet = 0;
    int  idle_pct = 27;
    int  hold_asked = 0;
    int  hold_seen = 0;
    int  hold_left = 0;
    logic in_taken = 1'b0;

    // Clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [5:0] lim_base(input logic [5:0] b);
        logic [5:0] r;
        r = b;
        if (r < 6'd2)
            r = 6'd2;
        if (r > 6'd36)
            r = 6'd36;
        return r;
    endfunction

    function automatic logic [7:0] glyph_of(input logic [5:0] d);
        logic [7:0] c;
        if (d < 6'd10)
            c = 8'd48 + {2'b00, d};
        else
            c = 8'd55 + {2'b00, d};
        return c;
    endfunction

    // Fold one character into the accumulator; on the last one, queue the
    // digits of the value in the output radix, most significant first
    function automatic void fold_char(input logic [7:0] code, input logic last);
        logic [63:0] dv;
        logic [63:0] v;
        logic [63:0] ob;
        logic [5:0]  stk[64];
        int          n;
        char_item_t  o;
        if (code >= 8'd48 && code <= 8'd58)
            dv = 64'(code) - 64'd48;
        else
            dv = 64'(code) - 64'd55;
        acc_q = acc_q * {58'd0, lim_base(in_base_q)} + dv;
        if (!last)
            return;
        v = acc_q;
        acc_q = '0;
        if (v == 64'd0)
        begin
            o.ch = 8'd48;
            o.last = 1'b1;
            want_q.push_back(o);
            return;
        end
        ob = {58'd0, lim_base(out_base_q)};
        n = 0;
        while (v != 64'd0 && n < 64)
        begin
            stk[n] = 6'(v % ob);
            v = v / ob;
            n++;
        end
        for (int i = n - 1; i >= 0; i--)
        begin
            o.ch = glyph_of(stk[i]);
            o.last = (i == 0);
            want_q.push_back(o);
        end
    endfunction

    task automatic report_bad(input string msg);
        n_err++;
        if (n_err <= 10)
            $display("%0t ERROR: %s", $time, msg);
    endtask

    // Monitor: register writes, input transfers, output checks, watchdog
    always @(posedge clk or negedge rst_n)
    begin
        char_item_t e;
        bit         moved;
        if (!rst_n)
        begin
            acc_q = '0;
            in_base_q = 6'd10;
            out_base_q = 6'd10;
            in_taken <= 1'b0;
        end
        else
        begin
            moved = 1'b0;
            if (psel && penable && pwrite && pready)
            begin
                moved = 1'b1;
                n_cfg++;
                if (paddr == ADDR_IN_BASE)
                    in_base_q = pwdata[5:0];
                else if (paddr == ADDR_OUT_BASE)
                    out_base_q = pwdata[5:0];
            end
            in_taken <= s_axis_tvalid && s_axis_tready;
            if (s_axis_tvalid && s_axis_tready)
            begin
                moved = 1'b1;
                n_in++;
                fold_char(s_axis_tdata, s_axis_tlast);
                if (send_q.size() > 0)
                    void'(send_q.pop_front());
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                moved = 1'b1;
                n_out++;
                if (want_q.size() == 0)
                    report_bad($sformatf("unexpected output char=%02h last=%0b",
                                         m_axis_tdata, m_axis_tlast));
                else
                begin
                    e = want_q.pop_front();
                    if (m_axis_tdata !== e.ch || m_axis_tlast !== e.last)
                        report_bad($sformatf(
                            "output %0d: expected char=%02h last=%0b, got char=%02h last=%0b",
                            n_out, e.ch, e.last, m_axis_tdata, m_axis_tlast));
                end
            end
            quiet = moved ? 0 : quiet + 1;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("Watchdog: %0d cycles without a transfer", quiet);
                $display("radix_base_converter_top verification failed");
                $finish;
            end
        end
    end

    // Source driver: holds an offered item until it is taken
    always @(negedge clk)
    begin
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else if (!s_axis_tvalid || in_taken)
        begin
            if (send_q.size() > 0 && $urandom_range(99) >= idle_pct)
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= send_q[0].ch;
                s_axis_tlast  <= send_q[0].last;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // Sink: random back-pressure plus a requested long hold-off
    always @(negedge clk)
    begin
        if (hold_seen != hold_asked)
        begin
            hold_seen = hold_asked;
            hold_left = HOLD_CYCLES;
        end
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= idle_pct);
    end

    task automatic cfg_write(input logic [PADDR_W-1:0] addr, input logic [5:0] val);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {26'($urandom()), val};
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic push_char(input logic [7:0] ch, input logic last);
        char_item_t it;
        it.ch = ch;
        it.last = last;
        send_q.push_back(it);
        n_queued++;
        if (last)
            n_numbers++;
    endtask

    // One number of len characters; noisy ones use any code and stray lasts
    task automatic push_number(input int len, input bit noisy, input bit zeros);
        logic [5:0] ib;
        logic [5:0] d;
        ib = lim_base(in_base_q);
        for (int i = 0; i < len; i++)
        begin
            if (noisy)
                push_char(8'($urandom_range(255)),
                          (i == len - 1) || ($urandom_range(3) == 0));
            else
            begin
                d = zeros ? 6'd0 : 6'($urandom_range(ib - 1));
                push_char(glyph_of(d), i == len - 1);
            end
        end
    endtask

    // Sender pauses until all items are taken and all results are in
    task automatic drain();
        while (send_q.size() != 0 || want_q.size() != 0)
            @(negedge clk);
        repeat (60) @(negedge clk);
    endtask

    task automatic set_bases(input logic [5:0] ib, input logic [5:0] ob);
        cfg_write(ADDR_IN_BASE, ib);
        cfg_write(ADDR_OUT_BASE, ob);
        @(posedge clk);
    endtask

    function automatic logic [5:0] pick_base();
        int r;
        r = $urandom_range(99);
        if (r < 70)
            return 6'($urandom_range(36, 2));
        else if (r < 85)
            return ($urandom_range(1) != 0) ? 6'd2 : 6'd36;
        else
            return 6'($urandom_range(63));
    endfunction

    // Stimulus
    initial
    begin
        int phase;
        int nnum;
        int len;
        int r;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // Reset radices: zero value, plain decimal, odd codes
        push_char("0", 1'b1);
        push_char("1", 1'b0);
        push_char("2", 1'b0);
        push_char("3", 1'b1);
        push_char(":", 1'b0);
        push_char(";", 1'b0);
        push_char("/", 1'b0);
        push_char("z", 1'b0);
        push_char(8'hFF, 1'b0);
        push_char(8'h00, 1'b1);
        drain();

        // Radices below and above range are clamped
        set_bases(6'd0, 6'd63);
        push_char("1", 1'b0);
        push_char("0", 1'b0);
        push_char("1", 1'b0);
        push_char("1", 1'b1);
        push_char(8'h00, 1'b1);
        drain();

        // Near-full accumulator in binary: the longest output
        set_bases(6'd37, 6'd1);
        push_char("Z", 1'b1);
        push_char(8'h00, 1'b1);
        drain();

        set_bases(6'd36, 6'd36);
        push_char("Z", 1'b0);
        push_char("Z", 1'b1);
        drain();
        set_bases(6'd2, 6'd2);
        push_char("1", 1'b1);
        drain();

        // Random phases with fresh radices each time
        phase = 0;
        while (n_queued < ITEM_TARGET)
        begin
            phase++;
            set_bases(pick_base(), pick_base());
            idle_pct = (phase == 3) ? 0 : 27;
            if (phase == 5)
                hold_asked++;
            nnum = $urandom_range(7, 3);
            for (int k = 0; k < nnum; k++)
            begin
                r = $urandom_range(99);
                if (r < 80)
                    len = $urandom_range(8, 1);
                else if (r < 95)
                    len = $urandom_range(16, 9);
                else
                    len = $urandom_range(24, 17);
                r = $urandom_range(99);
                push_number(len, r < 15, r >= 15 && r < 20);
            end
            drain();
        end
        idle_pct = 27;

        $display("Covered %0d input transfers in %0d numbers over %0d random phases,",
                 n_in, n_numbers, phase);
        $display("%0d output digits checked, %0d register writes", n_out, n_cfg);
        if (n_err == 0 && want_q.size() == 0)
            $display("radix_base_converter_top verification clean");
        else
            $display("radix_base_converter_top verification failed");
        $finish;
    end

endmodule
